// ----- src/hft_pkg.sv -----
// shared types and constants for the huffman tree build and decode unit
// no dependencies; used by hft_ctrl, hft_dpath and the top level
package hft_pkg;

  localparam int MAX_SYMBOLS = 256;
  localparam int COUNT_WIDTH = 32;
  localparam int NODE_DEPTH  = 2 * MAX_SYMBOLS - 1;
  localparam int NODE_W      = $clog2(NODE_DEPTH);
  localparam int WEIGHT_W    = 40;
  localparam int SYM_W       = 8;
  localparam int IDX_W       = 8;
  localparam int SCOUNT_W    = 9;
  localparam int CFG_DATA_W  = 9;

  typedef enum logic [1:0] {
    OP_LOAD   = 2'd0,
    OP_BUILD  = 2'd1,
    OP_DECODE = 2'd2,
    OP_UNUSED = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    KIND_SYMBOL = 2'd0,
    KIND_BUILT  = 2'd1,
    KIND_REJECT = 2'd2
  } kind_e;

  typedef enum logic {
    REG_START_SYMBOL = 1'b0,
    REG_SYMBOL_COUNT = 1'b1
  } reg_e;

  // controller to datapath commands
  typedef struct packed {
    logic  leaf_wr;
    logic  clr_start;
    logic  clr_wr;
    logic  pos_init;
    logic  pos_inc;
    logic  scan_start;
    logic  scan_step;
    logic  mark_lt;
    logic  mark_rt;
    logic  ptr_root;
    logic  dec_read;
    logic  dec_done;
    logic  out_load;
    kind_e out_kind;
  } cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic load_oob;
    logic clr_last;
    logic scan_last;
    logic pos_last;
    logic dec_leaf;
  } sts_t;

endpackage

// ----- src/huffman_tree_build_and_decode_unit.sv -----
// top level of the huffman tree build and decode unit
// instantiates hft_ctrl and hft_dpath; depends on hft_pkg
//
// usage: the input channel (in_valid_i / in_stall_o) takes one item with an
// operation: load a leaf count, build the tree, or decode one code bit.
// the output channel (out_valid_o / out_stall_i) returns kind and symbol.
// a good load gives no result; a bad index, a code bit before a build and an
// unused operation are rejected; the reject shows in the cycle after the item.
// decode does a child memory read, then a step, for each code bit;
// a leaf gives a symbol, an inner node gives no result.
// build: a sweep clears the merged flags, then each merge scans the node
// memory one entry per cycle to find the two smallest unmerged nodes.
// one item at a time: the input stalls while a build or a decode runs.
// a result waits in an output register; while it waits and the receiver
// stalls, the input stalls too, and the next item is taken at the edge where
// the waiting result leaves. reset clears control state; counts and tree are
// unknown until loaded and built. config writes go through cfg_we_i; the user
// must make them only while idle, as the block itself does not enforce this.
module huffman_tree_build_and_decode_unit (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  logic [1:0]                      operation_i,
  input  logic [hft_pkg::IDX_W-1:0]       symbol_index_i,
  input  logic [hft_pkg::COUNT_WIDTH-1:0] count_i,
  input  logic                            code_bit_i,
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output logic [1:0]                      kind_o,
  output logic [hft_pkg::SYM_W-1:0]       symbol_o,
  input  logic                            cfg_we_i,
  input  logic                            cfg_idx_i,
  input  logic [hft_pkg::CFG_DATA_W-1:0]  cfg_data_i
);

  hft_pkg::cmd_t cmd;
  hft_pkg::sts_t sts;

  // controller
  hft_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .operation_i (operation_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  // datapath
  hft_dpath u_dpath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .symbol_index_i (symbol_index_i),
    .count_i        (count_i),
    .code_bit_i     (code_bit_i),
    .cfg_we_i       (cfg_we_i),
    .cfg_idx_i      (cfg_idx_i),
    .cfg_data_i     (cfg_data_i),
    .cmd_i          (cmd),
    .sts_o          (sts),
    .kind_o         (kind_o),
    .symbol_o       (symbol_o)
  );

endmodule

// ----- src/hft_ctrl.sv -----
// controller state machine: sequences loads, tree build and decode
// depends on hft_pkg
module hft_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_stall_o,
  input  logic [1:0]    operation_i,
  output logic          out_valid_o,
  input  logic          out_stall_i,
  input  logic          cfg_we_i,
  input  logic          cfg_idx_i,
  input  hft_pkg::sts_t sts_i,
  output hft_pkg::cmd_t cmd_o
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_CLEAR,
    S_SCAN,
    S_SCAN_LAST,
    S_MARK_LT,
    S_MARK_RT,
    S_DECODE
  } state_e;

  state_e state_q, state_d;
  logic   tree_ready_q, tree_ready_d;
  logic   out_valid_q, out_valid_d;
  logic   accept;
  hft_pkg::op_e op;

  assign op          = hft_pkg::op_e'(operation_i);
  assign in_stall_o  = !((state_q == S_IDLE) && (!out_valid_q || !out_stall_i));
  assign accept      = in_valid_i && !in_stall_o;
  assign out_valid_o = out_valid_q;

  // next state and commands
  always_comb begin
    state_d      = state_q;
    tree_ready_d = tree_ready_q;
    cmd_o        = '0;
    cmd_o.out_kind = hft_pkg::KIND_REJECT;
    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          unique case (op)
            hft_pkg::OP_LOAD: begin
              if (sts_i.load_oob) begin
                cmd_o.out_load = 1'b1;
              end else begin
                cmd_o.leaf_wr = 1'b1;
              end
            end
            hft_pkg::OP_BUILD: begin
              cmd_o.clr_start = 1'b1;
              state_d = S_CLEAR;
            end
            hft_pkg::OP_DECODE: begin
              if (tree_ready_q) begin
                cmd_o.dec_read = 1'b1;
                state_d = S_DECODE;
              end else begin
                cmd_o.out_load = 1'b1;
              end
            end
            default: cmd_o.out_load = 1'b1;
          endcase
        end
      end
      S_CLEAR: begin
        cmd_o.clr_wr = 1'b1;
        if (sts_i.clr_last) begin
          cmd_o.pos_init   = 1'b1;
          cmd_o.scan_start = 1'b1;
          state_d = S_SCAN;
        end
      end
      S_SCAN: begin
        cmd_o.scan_step = 1'b1;
        if (sts_i.scan_last) state_d = S_SCAN_LAST;
      end
      S_SCAN_LAST: state_d = S_MARK_LT;
      S_MARK_LT: begin
        cmd_o.mark_lt = 1'b1;
        state_d = S_MARK_RT;
      end
      S_MARK_RT: begin
        cmd_o.mark_rt = 1'b1;
        if (sts_i.pos_last) begin
          cmd_o.ptr_root = 1'b1;
          cmd_o.out_load = 1'b1;
          cmd_o.out_kind = hft_pkg::KIND_BUILT;
          tree_ready_d   = 1'b1;
          state_d = S_IDLE;
        end else begin
          cmd_o.pos_inc    = 1'b1;
          cmd_o.scan_start = 1'b1;
          state_d = S_SCAN;
        end
      end
      S_DECODE: begin
        cmd_o.dec_done = 1'b1;
        if (sts_i.dec_leaf) begin
          cmd_o.out_load = 1'b1;
          cmd_o.out_kind = hft_pkg::KIND_SYMBOL;
        end
        state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
    // a new symbol count needs a new build
    if (cfg_we_i && (hft_pkg::reg_e'(cfg_idx_i) == hft_pkg::REG_SYMBOL_COUNT)) begin
      tree_ready_d = 1'b0;
    end
  end

  // output slot: set on a new result, cleared when taken
  always_comb begin
    out_valid_d = out_valid_q;
    if (out_valid_q && !out_stall_i) out_valid_d = 1'b0;
    if (cmd_o.out_load) out_valid_d = 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      tree_ready_q <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q      <= state_d;
      tree_ready_q <= tree_ready_d;
      out_valid_q  <= out_valid_d;
    end
  end

`ifndef NO_ASSERTIONS
  a_busy_stalls: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != S_IDLE) |-> in_stall_o)
    else $error("input taken while busy");
  a_mark_pair: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_MARK_LT) |=> (state_q == S_MARK_RT))
    else $error("merge marks out of order");
  a_decode_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DECODE) |-> tree_ready_q)
    else $error("decode without a built tree");
  a_scan_tail: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_SCAN_LAST) |-> $past(state_q == S_SCAN))
    else $error("scan tail without scan");
`endif

endmodule

// ----- src/hft_dpath.sv -----
// datapath: config registers, node memories, min-pair scan, decode pointer
// depends on hft_pkg
module hft_dpath (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic [hft_pkg::IDX_W-1:0]          symbol_index_i,
  input  logic [hft_pkg::COUNT_WIDTH-1:0]    count_i,
  input  logic                               code_bit_i,
  input  logic                               cfg_we_i,
  input  logic                               cfg_idx_i,
  input  logic [hft_pkg::CFG_DATA_W-1:0]     cfg_data_i,
  input  hft_pkg::cmd_t                      cmd_i,
  output hft_pkg::sts_t                      sts_o,
  output logic [1:0]                         kind_o,
  output logic [hft_pkg::SYM_W-1:0]          symbol_o
);

  localparam int NW = hft_pkg::NODE_W;
  localparam int WW = hft_pkg::WEIGHT_W;

  // node memories
  logic [WW-1:0]   weight_mem [hft_pkg::NODE_DEPTH];
  logic            merged_mem [hft_pkg::NODE_DEPTH];
  logic [2*NW-1:0] child_mem  [hft_pkg::NODE_DEPTH];

  logic [hft_pkg::SYM_W-1:0]    start_q;
  logic [hft_pkg::SCOUNT_W-1:0] scount_q;
  logic [NW-1:0] n, root, ctr_q, pos_q, ptr_q, ptr_eff;
  logic [NW-1:0] b1_q, b2_q, rd_idx_q;
  logic [WW-1:0] w1_q, w2_q, rd_w_q;
  logic          f1_q, f2_q, rd_vld_q, rd_merged_q, bit_q;
  logic [2*NW-1:0] rd_child_q;
  logic [NW-1:0] child_sel, next;
  logic [1:0]    kind_q;
  logic [hft_pkg::SYM_W-1:0] symbol_q;

  // leaves in use, saturated into 2..MAX_SYMBOLS
  always_comb begin
    if (scount_q < NW'(2)) n = NW'(2);
    else if (scount_q > NW'(hft_pkg::MAX_SYMBOLS)) n = NW'(hft_pkg::MAX_SYMBOLS);
    else n = NW'(scount_q);
  end
  assign root = NW'({n, 1'b0} - 2);

  assign ptr_eff   = ((ptr_q < n) || (ptr_q > root)) ? root : ptr_q;
  assign child_sel = bit_q ? rd_child_q[2*NW-1:NW] : rd_child_q[NW-1:0];
  assign next      = (child_sel > root) ? root : child_sel;

  assign sts_o.load_oob  = NW'(symbol_index_i) >= n;
  assign sts_o.clr_last  = ctr_q == root;
  assign sts_o.scan_last = ctr_q == NW'(pos_q - 1'b1);
  assign sts_o.pos_last  = pos_q == root;
  assign sts_o.dec_leaf  = next < n;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_q  <= '0;
      scount_q <= hft_pkg::SCOUNT_W'(hft_pkg::MAX_SYMBOLS);
    end else if (cfg_we_i) begin
      unique case (hft_pkg::reg_e'(cfg_idx_i))
        hft_pkg::REG_START_SYMBOL: start_q  <= cfg_data_i[hft_pkg::SYM_W-1:0];
        hft_pkg::REG_SYMBOL_COUNT: scount_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // weight memory: leaf loads and new node sums, scan read
  always_ff @(posedge clk_i) begin
    if (cmd_i.leaf_wr) begin
      weight_mem[NW'(symbol_index_i)] <= WW'(count_i);
    end else if (cmd_i.mark_lt) begin
      weight_mem[pos_q] <= w1_q + w2_q;
    end
    rd_w_q <= weight_mem[ctr_q];
  end

  // merged flags: cleared by the sweep, set by each merge
  always_ff @(posedge clk_i) begin
    priority if (cmd_i.clr_wr) merged_mem[ctr_q] <= 1'b0;
    else if (cmd_i.mark_lt)    merged_mem[b1_q]  <= 1'b1;
    else if (cmd_i.mark_rt)    merged_mem[b2_q]  <= 1'b1;
    rd_merged_q <= merged_mem[ctr_q];
  end

  // child memory: {right, left}
  always_ff @(posedge clk_i) begin
    if (cmd_i.mark_lt) child_mem[pos_q] <= {b2_q, b1_q};
    if (cmd_i.dec_read) begin
      rd_child_q <= child_mem[ptr_eff];
      bit_q      <= code_bit_i;
    end
  end

  // sweep and scan counters, scan read tag
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctr_q    <= '0;
      pos_q    <= '0;
      rd_vld_q <= 1'b0;
      rd_idx_q <= '0;
    end else begin
      if (cmd_i.clr_start || cmd_i.scan_start) ctr_q <= '0;
      else if (cmd_i.clr_wr || cmd_i.scan_step) ctr_q <= ctr_q + 1'b1;
      if (cmd_i.pos_init) pos_q <= n;
      else if (cmd_i.pos_inc) pos_q <= pos_q + 1'b1;
      rd_vld_q <= cmd_i.scan_step;
      rd_idx_q <= ctr_q;
    end
  end

  // running smallest and second smallest; strict compare keeps lowest index
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      f1_q <= 1'b0;
      f2_q <= 1'b0;
      b1_q <= '0;
      b2_q <= '0;
      w1_q <= '0;
      w2_q <= '0;
    end else if (cmd_i.scan_start) begin
      f1_q <= 1'b0;
      f2_q <= 1'b0;
    end else if (rd_vld_q && !rd_merged_q) begin
      if (!f1_q || rd_w_q < w1_q) begin
        f1_q <= 1'b1;
        f2_q <= f1_q;
        b2_q <= b1_q;
        w2_q <= w1_q;
        b1_q <= rd_idx_q;
        w1_q <= rd_w_q;
      end else if (!f2_q || rd_w_q < w2_q) begin
        f2_q <= 1'b1;
        b2_q <= rd_idx_q;
        w2_q <= rd_w_q;
      end
    end
  end

  // decode pointer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ptr_q <= '0;
    end else if (cmd_i.ptr_root) begin
      ptr_q <= root;
    end else if (cmd_i.dec_done) begin
      ptr_q <= (next < n) ? root : next;
    end
  end

  // result payload
  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      kind_q <= cmd_i.out_kind;
      if (cmd_i.out_kind == hft_pkg::KIND_SYMBOL) begin
        symbol_q <= start_q + next[hft_pkg::SYM_W-1:0];
      end else begin
        symbol_q <= '0;
      end
    end
  end

  assign kind_o   = kind_q;
  assign symbol_o = symbol_q;

endmodule
